@@ sv/sptt_pkg.sv @@
// Package for the sparse polynomial term table.
// Holds sizes, widths and action codes; no dependencies.
package sptt_pkg;
  localparam int MAX_TERMS = 32;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int OUT_CNT_W = 6;
  localparam int EXPO_W    = 16;
  localparam int COEF_W    = 32;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_EVAL  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [EXPO_W-1:0] expo;
    logic [COEF_W-1:0] coef;
  } term_t;
endpackage

@@ sv/sparse_polynomial_term_table.sv @@
// Top level of the sparse polynomial term table.
// Depends on sptt_pkg. Terms live in one synchronous memory.
//
//  channel | ports                               | handshake
//  input   | in_action in_coef_in in_expo_in ... | start high, busy low
//  result  | out_value out_term_count out_dropped| out_valid for one cycle
//
// Add: a scan reads the table one entry at a time (issue read, check data),
// then a merge write, or a shift pass that moves up to MAX_TERMS-1 entries.
// Evaluate: per entry one read, one load, a multiply and a squaring step per
// exponent bit (up to 16 bits), then coef*power and accumulate.
// Clear zeroes the count. Reset empties the table at once (count only).
// The receiver cannot stall; busy stays high until the result strobe.
module sparse_polynomial_term_table
  import sptt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_action,
  input  logic signed [COEF_W-1:0]    in_coef_in,
  input  logic [EXPO_W-1:0]           in_expo_in,
  input  logic signed [COEF_W-1:0]    in_point,
  output logic                        out_valid,
  output logic signed [COEF_W-1:0]    out_value,
  output logic [OUT_CNT_W-1:0]        out_term_count,
  output logic                        out_dropped
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRD   = 4'd1;  // scan: issue read
  localparam logic [3:0] S_SCHK  = 4'd2;  // scan: check data
  localparam logic [3:0] S_MRG   = 4'd3;  // write merged coefficient
  localparam logic [3:0] S_DRD   = 4'd4;  // delete shift: read k+1
  localparam logic [3:0] S_DWR   = 4'd5;  // delete shift: write k
  localparam logic [3:0] S_IRD   = 4'd6;  // insert shift: read k-1
  localparam logic [3:0] S_IWR   = 4'd7;  // insert shift: write k
  localparam logic [3:0] S_ERD   = 4'd8;  // eval: issue read
  localparam logic [3:0] S_ELD   = 4'd9;  // eval: load term
  localparam logic [3:0] S_EPW   = 4'd10; // eval: power step
  localparam logic [3:0] S_EACC  = 4'd11; // eval: coef*power
  localparam logic [3:0] S_EADD  = 4'd12; // eval: accumulate
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]        state_r;
  logic [1:0]        act_r;
  logic [COEF_W-1:0] coef_r, x_r;
  logic [EXPO_W-1:0] expo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  k_r;
  logic [COEF_W-1:0] acc_r, base_r, pw_r, sum_r, prod_r;
  logic [EXPO_W-1:0] e_r;
  logic [COEF_W-1:0] tcoef_r;
  logic              mul_ph_r;
  logic              dropped_r;

  // Term memory, one read and one write port, registered read data
  term_t             mem [MAX_TERMS];
  term_t             rd_q;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic              wr_en;
  term_t             wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Shared 32x32 multiplier, low word only
  logic [COEF_W-1:0] mul_a, mul_b, mul_p;
  logic [2*COEF_W-1:0] mul_full;
  assign mul_full = mul_a * mul_b;
  assign mul_p    = mul_full[COEF_W-1:0];

  logic [COEF_W-1:0] merged;
  assign merged = rd_q.coef + coef_r;

  always_comb begin
    rd_addr = i_r[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = i_r[IDX_W-1:0];
    wr_data = rd_q;
    mul_a   = acc_r;
    mul_b   = base_r;
    unique case (state_r)
      S_MRG: begin
        wr_en        = (merged != '0);
        wr_data.expo = rd_q.expo;
        wr_data.coef = merged;
      end
      S_DRD: rd_addr = IDX_W'(k_r + 1'b1);
      S_DWR: begin
        wr_en   = 1'b1;
        wr_addr = k_r[IDX_W-1:0];
      end
      S_IRD: rd_addr = IDX_W'(k_r - 1'b1);
      S_IWR: begin
        wr_en   = 1'b1;
        wr_addr = k_r[IDX_W-1:0];
        if (k_r == i_r) begin
          wr_data.expo = expo_r;
          wr_data.coef = coef_r;
        end
      end
      S_EPW: begin
        if (mul_ph_r) begin
          mul_a = base_r;
        end
      end
      S_EACC: begin
        mul_a = tcoef_r;
        mul_b = pw_r;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            act_r     <= in_action;
            coef_r    <= in_coef_in;
            expo_r    <= in_expo_in;
            x_r       <= in_point;
            i_r       <= '0;
            sum_r     <= '0;
            dropped_r <= 1'b0;
            priority if (in_action == ACT_ADD && in_coef_in != '0) state_r <= S_SRD;
            else if (in_action == ACT_EVAL) state_r <= S_ERD;
            else begin
              if (in_action == ACT_CLEAR) cnt_r <= '0;
              state_r <= S_DONE;
            end
          end
        end
        // Scan for the first entry whose exponent is not above the new one
        S_SRD: begin
          if (i_r >= cnt_r) begin
            // insert at end
            if (cnt_r >= CNT_W'(MAX_TERMS)) begin
              dropped_r <= 1'b1;
              state_r   <= S_DONE;
            end else begin
              k_r     <= cnt_r;
              state_r <= (cnt_r == i_r) ? S_IWR : S_IRD;
            end
          end else begin
            state_r <= S_SCHK;
          end
        end
        S_SCHK: begin
          priority if (rd_q.expo > expo_r) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_SRD;
          end else if (rd_q.expo == expo_r) begin
            state_r <= S_MRG;
          end else if (cnt_r >= CNT_W'(MAX_TERMS)) begin
            dropped_r <= 1'b1;
            state_r   <= S_DONE;
          end else begin
            k_r     <= cnt_r;
            state_r <= S_IRD;
          end
        end
        S_MRG: begin
          if (merged == '0) begin
            k_r     <= i_r;
            state_r <= S_DRD;
          end else begin
            state_r <= S_DONE;
          end
        end
        // Pull entries after a removed one up by one place
        S_DRD: begin
          if (k_r + 1'b1 >= cnt_r) begin
            cnt_r   <= cnt_r - 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_DWR;
          end
        end
        S_DWR: begin
          k_r     <= k_r + 1'b1;
          state_r <= S_DRD;
        end
        // Push entries down to open a slot, then write the new term
        S_IRD: state_r <= S_IWR;
        S_IWR: begin
          if (k_r == i_r) begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_DONE;
          end else begin
            k_r     <= k_r - 1'b1;
            state_r <= (k_r - 1'b1 == i_r) ? S_IWR : S_IRD;
          end
        end
        // Evaluate: square-and-multiply per term
        S_ERD: state_r <= (i_r >= cnt_r) ? S_DONE : S_ELD;
        S_ELD: begin
          e_r      <= rd_q.expo;
          tcoef_r  <= rd_q.coef;
          acc_r    <= COEF_W'(1);
          base_r   <= x_r;
          mul_ph_r <= 1'b0;
          state_r  <= S_EPW;
        end
        S_EPW: begin
          if (e_r == '0) begin
            pw_r    <= acc_r;
            state_r <= S_EACC;
          end else if (!mul_ph_r) begin
            if (e_r[0]) acc_r <= mul_p;
            mul_ph_r <= 1'b1;
          end else begin
            base_r   <= mul_p;
            e_r      <= e_r >> 1;
            mul_ph_r <= 1'b0;
          end
        end
        S_EACC: begin
          prod_r  <= mul_p;
          state_r <= S_EADD;
        end
        S_EADD: begin
          sum_r   <= sum_r + prod_r;
          i_r     <= i_r + 1'b1;
          state_r <= S_ERD;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Hold result payload for the strobe cycle
  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_value      <= (act_r == ACT_EVAL) ? sum_r : '0;
      out_term_count <= OUT_CNT_W'(cnt_r);
      out_dropped    <= dropped_r;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TERMS)) else $error("term count over capacity");
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> cnt_r == CNT_W'(MAX_TERMS))
    else $error("drop flagged with room left");
`endif

endmodule

@@ test/tb_sparse_polynomial_term_table.sv @@
// Testbench for sparse_polynomial_term_table: directed and random add, evaluate
// and clear transfers, checked against an in-bench model of the term table.
// Depends on sptt_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_sparse_polynomial_term_table;
  import sptt_pkg::*;

  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [COEF_W-1:0]    value;
    logic [OUT_CNT_W-1:0] count;
    logic                 dropped;
  } poly_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = ACT_NOP;
  logic signed [COEF_W-1:0] in_coef_in = '0;
  logic [EXPO_W-1:0] in_expo_in = '0;
  logic signed [COEF_W-1:0] in_point = '0;
  logic out_valid;
  logic signed [COEF_W-1:0] out_value;
  logic [OUT_CNT_W-1:0] out_term_count;
  logic out_dropped;

  // model of the table contents
  logic [EXPO_W-1:0] poly_expo[MAX_TERMS];
  logic [COEF_W-1:0] poly_coef[MAX_TERMS];
  int poly_len = 0;

  poly_result_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;

  sparse_polynomial_term_table i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_coef_in(in_coef_in), .in_expo_in(in_expo_in),
    .in_point(in_point), .out_valid(out_valid), .out_value(out_value),
    .out_term_count(out_term_count), .out_dropped(out_dropped)
  );

  always #6 clk = ~clk;

  // x^e with 32-bit wraparound, square and multiply
  function automatic logic [COEF_W-1:0] wrap_power(logic [COEF_W-1:0] x,
                                                   logic [EXPO_W-1:0] e);
    logic [COEF_W-1:0] acc;
    acc = 1;
    for (int b = 0; b < EXPO_W; b++) begin
      if (e[b]) acc = acc * x;
      x = x * x;
    end
    return acc;
  endfunction

  // merge one term into the table; returns 1 when it must be dropped
  function automatic bit merge_term(logic [COEF_W-1:0] c, logic [EXPO_W-1:0] e);
    int i;
    i = 0;
    if (c == 0) return 1'b0;
    while (i < poly_len && poly_expo[i] > e) i++;
    if (i < poly_len && poly_expo[i] == e) begin
      poly_coef[i] = poly_coef[i] + c;
      if (poly_coef[i] == 0) begin
        for (int k = i; k + 1 < poly_len; k++) begin
          poly_expo[k] = poly_expo[k + 1];
          poly_coef[k] = poly_coef[k + 1];
        end
        poly_len--;
      end
      return 1'b0;
    end
    if (poly_len >= MAX_TERMS) return 1'b1;
    for (int k = poly_len; k > i; k--) begin
      poly_expo[k] = poly_expo[k - 1];
      poly_coef[k] = poly_coef[k - 1];
    end
    poly_expo[i] = e;
    poly_coef[i] = c;
    poly_len++;
    return 1'b0;
  endfunction

  function automatic poly_result_t predict_result(logic [1:0] act, logic [COEF_W-1:0] c,
                                                  logic [EXPO_W-1:0] e, logic [COEF_W-1:0] x);
    poly_result_t r;
    r.value = '0;
    r.dropped = 1'b0;
    case (act)
      ACT_ADD: r.dropped = merge_term(c, e);
      ACT_EVAL: begin
        for (int i = 0; i < poly_len; i++)
          r.value = r.value + poly_coef[i] * wrap_power(x, poly_expo[i]);
      end
      ACT_CLEAR: poly_len = 0;
      default: ;
    endcase
    r.count = poly_len[OUT_CNT_W-1:0];
    return r;
  endfunction

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // send one transfer, with an optional idle burst in front
  task automatic send_item(logic [1:0] act, logic [COEF_W-1:0] c,
                           logic [EXPO_W-1:0] e, logic [COEF_W-1:0] x);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action = act;
    in_coef_in = c;
    in_expo_in = e;
    in_point = x;
    start = 1'b1;
    // busy is stable at the falling edge; the next rising edge takes the transfer
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(predict_result(act, c, e, x));
  endtask

  // hold the sender until every result is back
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    wait (pending_results.size() == 0);
  endtask

  // check each result strobe against the oldest expectation
  always @(posedge clk) begin
    poly_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value)
          report($sformatf("value %h, expected %h", out_value, want.value));
        if (out_term_count !== want.count)
          report($sformatf("term_count %0d, expected %0d", out_term_count, want.count));
        if (out_dropped !== want.dropped)
          report($sformatf("dropped %b, expected %b", out_dropped, want.dropped));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_sparse_polynomial_term_table: errors");
      $finish;
    end
  end

  // edges of the fields, overflow, cancellation, zero to the zero, unused action
  task automatic test_directed();
    send_item(ACT_EVAL, 0, 0, 32'h7fffffff);
    send_item(ACT_ADD, 0, 16'd5, 0);
    send_item(ACT_ADD, 32'h7fffffff, 16'hffff, 0);
    send_item(ACT_ADD, 32'h80000000, 16'd0, 0);
    send_item(ACT_ADD, 32'h7fffffff, 16'd1, 0);
    send_item(ACT_ADD, 32'h00000002, 16'd1, 0);
    send_item(ACT_EVAL, 0, 0, 32'h00000000);
    send_item(ACT_EVAL, 0, 0, 32'hffffffff);
    send_item(ACT_EVAL, 0, 0, 32'h80000000);
    send_item(ACT_EVAL, 0, 0, 32'h7fffffff);
    send_item(ACT_ADD, 32'h80000001, 16'hffff, 0);
    send_item(ACT_NOP, 32'hffffffff, 16'hffff, 32'hffffffff);
    send_item(ACT_EVAL, 0, 0, 32'd3);
    send_item(ACT_CLEAR, 0, 0, 0);
    send_item(ACT_EVAL, 0, 0, 32'd3);
  endtask

  // fill the table, overflow it, then merge and evaluate while full
  task automatic test_full_table();
    for (int i = 0; i < MAX_TERMS + 2; i++)
      send_item(ACT_ADD, $urandom() | 1, 16'(i * 3), 0);
    send_item(ACT_ADD, 32'd7, 16'd3, 0);
    send_item(ACT_EVAL, 0, 0, 32'd2);
    send_item(ACT_ADD, -poly_coef[0], poly_expo[0], 0);
    send_item(ACT_ADD, 32'd9, 16'd1, 0);
    send_item(ACT_EVAL, 0, 0, $urandom());
    drain_results();
  endtask

  task automatic test_random(int count);
    int pick;
    int k;
    logic [COEF_W-1:0] c;
    logic [EXPO_W-1:0] e;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      c = ($urandom_range(0, 1) != 0) ? $urandom() : 32'($signed($urandom_range(0, 40)) - 20);
      e = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 40));
      if (pick < 55) begin
        send_item(ACT_ADD, c, e, $urandom());
      end else if (pick < 68 && poly_len > 0) begin
        // cancel or overflow an existing term
        k = $urandom_range(0, poly_len - 1);
        send_item(ACT_ADD, ($urandom_range(0, 2) != 0) ? -poly_coef[k] : c,
                  poly_expo[k], $urandom());
      end else if (pick < 92) begin
        send_item(ACT_EVAL, $urandom(), 16'($urandom()),
                  ($urandom_range(0, 1) != 0) ? $urandom() : 32'($signed($urandom_range(0, 6)) - 3));
      end else if (pick < 96) begin
        send_item(ACT_NOP, c, e, $urandom());
      end else begin
        send_item(ACT_CLEAR, c, e, $urandom());
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    drain_results();
    test_full_table();
    test_random(300);
    drain_results();
    gaps_on = 1'b0;
    test_random(120);
    drain_results();
    repeat (1200) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_sparse_polynomial_term_table: clean");
    end else begin
      $display("tb_sparse_polynomial_term_table: errors");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/sptt_pkg.sv
sv/sparse_polynomial_term_table.sv
test/tb_sparse_polynomial_term_table.sv
